@@ rtl/core/tbd_pkg.sv @@
// Package for the TEA block decryptor: widths, round count, key type and
// per-stage round constants. Depends on nothing; every core module imports it.

package tbd_pkg;

  // Word and configuration port widths.
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // Number of TEA rounds; each round is two pipeline stages (one per half).
  localparam int unsigned ROUNDS = 32;
  localparam int unsigned STAGES = 2 * ROUNDS;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t DELTA = 32'h9E37_79B9;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0 = 2'd0,
    REG_KEY1 = 2'd1,
    REG_KEY2 = 2'd2,
    REG_KEY3 = 2'd3
  } cfg_reg_t;

  // The 128-bit key as four words.
  typedef struct packed {
    word_t k0;
    word_t k1;
    word_t k2;
    word_t k3;
  } key_t;

  // Handshake between the last pipeline stage and the output skid stage.
  typedef struct packed {
    logic valid;
    logic adv;
  } pipe_ctl_t;

  // Running sum seen by a given round: DELTA times the rounds still to go,
  // wrapped to 32 bits. Only called with constant arguments.
  function automatic word_t tbd_round_sum(input int unsigned round_idx);
    word_t rounds_left;
    rounds_left = word_t'(ROUNDS - round_idx);
    return word_t'(DELTA * rounds_left);
  endfunction

endpackage

@@ rtl/core/tbd_key_regs.sv @@
// Key register file of the TEA block decryptor: four 32-bit key words
// written through the configuration port. Depends on tbd_pkg.

module tbd_key_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [tbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  tbd_pkg::word_t             cfg_wr_data,
  output tbd_pkg::key_t              key
);
  import tbd_pkg::*;

  key_t key_r;
  key_t key_nxt;

  // Decode the register index and replace the addressed word.
  always_comb begin
    key_nxt = key_r;
    if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KEY0: key_nxt.k0 = cfg_wr_data;
        REG_KEY1: key_nxt.k1 = cfg_wr_data;
        REG_KEY2: key_nxt.k2 = cfg_wr_data;
        REG_KEY3: key_nxt.k3 = cfg_wr_data;
        default:  key_nxt = key_r;
      endcase
    end
  end

  // The key resets to all zeros.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else begin
      key_r <= key_nxt;
    end
  end

  assign key = key_r;

endmodule

@@ rtl/core/tbd_stage.sv @@
// One half-round of TEA decryption as a pipeline stage: the updated word
// loses mix(kept word), and the top level trades the two words' roles
// between stages. Depends on tbd_pkg.

module tbd_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  tbd_pkg::word_t keep_in,
  input  tbd_pkg::word_t upd_in,
  input  tbd_pkg::word_t sum,
  input  tbd_pkg::word_t ka,
  input  tbd_pkg::word_t kb,
  output logic           out_vld,
  output tbd_pkg::word_t keep_out,
  output tbd_pkg::word_t upd_out
);
  import tbd_pkg::*;

  logic  vld_r;
  word_t keep_r;
  word_t upd_r;
  word_t mix;
  word_t upd_nxt;

  // TEA mixing function of the kept word, then the wrapping subtract.
  always_comb begin
    mix     = ((keep_in << 4) + ka) ^ (keep_in + sum) ^ ((keep_in >> 5) + kb);
    upd_nxt = upd_in - mix;
  end

  // Valid bit is control state and resets; the words are payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      keep_r <= keep_in;
      upd_r  <= upd_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign keep_out = keep_r;
  assign upd_out  = upd_r;

  // A frozen stage keeps its valid bit and updated word.
  a_hold_when_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r) && $stable(upd_r))
    else $error("tbd_stage: contents changed while frozen");

endmodule

@@ rtl/core/tbd_out_skid.sv @@
// Output skid stage of the TEA block decryptor: catches the last pipeline
// stage's transaction when the output stalls, so the pipeline stall comes
// from a register rather than straight from out_stall. Depends on tbd_pkg.

module tbd_out_skid (
  input  logic               clk,
  input  logic               rst_n,
  input  tbd_pkg::word_t     pipe_left,
  input  tbd_pkg::word_t     pipe_right,
  input  logic               pipe_valid,
  output tbd_pkg::pipe_ctl_t ctl,
  output logic               out_valid,
  input  logic               out_stall,
  output tbd_pkg::word_t     out_plain_left,
  output tbd_pkg::word_t     out_plain_right
);
  import tbd_pkg::*;

  logic  skid_v_r;
  logic  skid_v_nxt;
  word_t skid_left_r;
  word_t skid_right_r;

  // Fill when a result is stalled while the pipeline still moves; drain
  // when the held result is taken.
  always_comb begin
    skid_v_nxt = skid_v_r;
    if (skid_v_r) begin
      if (!out_stall) begin
        skid_v_nxt = 1'b0;
      end
    end else if (pipe_valid && out_stall) begin
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else begin
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r) begin
      skid_left_r  <= pipe_left;
      skid_right_r <= pipe_right;
    end
  end

  // The pipeline advances whenever the skid register is free.
  assign ctl.valid = pipe_valid;
  assign ctl.adv   = !skid_v_r;

  assign out_valid       = skid_v_r || pipe_valid;
  assign out_plain_left  = skid_v_r ? skid_left_r  : pipe_left;
  assign out_plain_right = skid_v_r ? skid_right_r : pipe_right;

  // The skid register only fills from a stalled, valid last stage.
  a_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !$past(skid_v_r) |-> $past(pipe_valid && out_stall))
    else $error("tbd_out_skid: skid filled without a stalled result");

  // A held result that is taken frees the skid register.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !out_stall |=> !skid_v_r)
    else $error("tbd_out_skid: skid register did not drain");

  // A held result stays on the output until it is taken.
  a_keep_held: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && out_stall |=> skid_v_r && $stable(skid_left_r))
    else $error("tbd_out_skid: held result lost");

endmodule

@@ rtl/core/tea_block_decrypt.sv @@
// TEA block decryptor, 32 rounds, top level. Each half-round is one
// register stage, so a cipher block passes 64 stages on its way to the
// output; one block is accepted in every cycle while the output keeps
// up. The add, xor and subtract of one half-round set the clock period.
// A stalled output is absorbed by a skid register: the input stalls in
// the cycle after the output stalls on a valid result and resumes in the
// cycle after the held result is taken. The key is written through the
// cfg_ port and should only change while no block is inside.
// Depends on tbd_pkg, tbd_key_regs, tbd_stage and tbd_out_skid.

module tea_block_decrypt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [tbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  tbd_pkg::word_t                cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  tbd_pkg::word_t                in_cipher_left,
  input  tbd_pkg::word_t                in_cipher_right,
  output logic                          out_valid,
  input  logic                          out_stall,
  output tbd_pkg::word_t                out_plain_left,
  output tbd_pkg::word_t                out_plain_right
);
  import tbd_pkg::*;

  key_t      key;
  pipe_ctl_t ctl;
  logic      st_vld  [STAGES+1];
  word_t     st_keep [STAGES+1];
  word_t     st_upd  [STAGES+1];

  // Key registers.
  tbd_key_regs u_keys (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .key         (key)
  );

  // The first stage updates the right word from the left one. Each stage
  // keeps the word that the previous stage updated, so the left word enters
  // on the updated side.
  assign st_vld[0]  = in_valid;
  assign st_keep[0] = in_cipher_right;
  assign st_upd[0]  = in_cipher_left;

  // Half-round pipeline; the words swap roles from one stage to the next.
  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    localparam word_t SUM = tbd_round_sum(g / 2);
    tbd_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (ctl.adv),
      .in_vld   (st_vld[g]),
      .keep_in  (st_upd[g]),
      .upd_in   (st_keep[g]),
      .sum      (SUM),
      .ka       ((g % 2 == 0) ? key.k2 : key.k0),
      .kb       ((g % 2 == 0) ? key.k3 : key.k1),
      .out_vld  (st_vld[g+1]),
      .keep_out (st_keep[g+1]),
      .upd_out  (st_upd[g+1])
    );
  end

  // After an even number of stages the kept word is the right one.
  tbd_out_skid u_skid (
    .clk             (clk),
    .rst_n           (rst_n),
    .pipe_left       (st_upd[STAGES]),
    .pipe_right      (st_keep[STAGES]),
    .pipe_valid      (st_vld[STAGES]),
    .ctl             (ctl),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_plain_left  (out_plain_left),
    .out_plain_right (out_plain_right)
  );

  assign in_stall = !ctl.adv;

  // An accepted transaction occupies the first stage on the next cycle.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> st_vld[1])
    else $error("tea_block_decrypt: accepted transaction did not enter");

endmodule
